@@ rtl/fpba_pkg.sv @@
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and codes for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int AMOUNT_W     = 16;
    localparam int LOAD_IDX_W   = 4;
    localparam int CHOSEN_W     = 4;
    localparam int LEFT_W       = 16;
    localparam int FIT_POLICY_W = 2;
    localparam int BIU_W        = 5;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;

    // request kinds
    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_ALLOCATE = 1'b1;

    // fit policies; the unused code behaves as first fit
    localparam logic [FIT_POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [FIT_POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [FIT_POLICY_W-1:0] POLICY_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_FIT_POLICY    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLOCKS_IN_USE = 1'd1;

    localparam logic [FIT_POLICY_W-1:0] FIT_POLICY_RESET = POLICY_FIRST;
    localparam logic [BIU_W-1:0]        BIU_RESET        = 5'd16;

    typedef struct packed {
        logic                  req_type;
        logic [LOAD_IDX_W-1:0] load_index;
        logic [AMOUNT_W-1:0]   amount;
    } req_t;

    typedef struct packed {
        logic                granted;
        logic [CHOSEN_W-1:0] chosen_block;
        logic [LEFT_W-1:0]   left_over;
    } rsp_t;

endpackage

@@ rtl/fpba_chan_if.sv @@
// ----------------------------------------------------------------------------
// fpba_chan_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface fpba_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/fit_policy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// Free-size table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// One request is handled at a time. A load writes one entry of the free-size
// table in the write state, then passes through the finish state. An allocate
// reads the table through its single read port, one entry per cycle, over n
// entries (min(blocks_in_use, NUM_BLOCKS); first fit stops at the first entry
// that fits), then passes through the write and finish states. The next
// request can be accepted in the same cycle that the result appears. A
// finished result sits in an output register, and the next request is
// accepted while it waits to be taken. The table reads as all zero after
// reset; no clearing pass is needed.
module fit_policy_block_allocator #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    fpba_chan_if.sink                          req,
    fpba_chan_if.source                        rsp,
    input  logic                               cfg_we,
    input  logic [fpba_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import fpba_pkg::*;

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    logic [FIT_POLICY_W-1:0] fit_policy_reg;
    logic [BIU_W-1:0]        blocks_in_use_reg;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [SIZE_BITS-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg    <= FIT_POLICY_RESET;
            blocks_in_use_reg <= BIU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIT_POLICY:    fit_policy_reg    <= FIT_POLICY_W'(cfg_wdata);
                CFG_BLOCKS_IN_USE: blocks_in_use_reg <= BIU_W'(cfg_wdata);
                default:           ;
            endcase
        end
    end

    fpba_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req.valid),
        .in_ready      (req.ready),
        .in_data       (req.data),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .out_data      (rsp.data),
        .fit_policy    (fit_policy_reg),
        .blocks_in_use (blocks_in_use_reg),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    fpba_mem #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ rtl/fpba_mem.sv @@
// ----------------------------------------------------------------------------
// fpba_mem
// Free-size table: one write port, one registered read port, with a valid
// bit per entry so that an entry never loaded reads as zero.
// ----------------------------------------------------------------------------
module fpba_mem #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  logic [SIZE_BITS-1:0] wdata,
    input  logic [IDX_W-1:0]     raddr,
    output logic [SIZE_BITS-1:0] rdata
);

    logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [SIZE_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

@@ rtl/fpba_ctrl.sv @@
// ----------------------------------------------------------------------------
// fpba_ctrl
// Request sequencer: scans the table one entry per cycle, keeps the running
// choice, writes the loaded or chosen entry and holds the result register.
// ----------------------------------------------------------------------------
module fpba_ctrl #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16,
    parameter int IDX_W      = 4,
    parameter int CNT_W      = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fpba_pkg::req_t                      in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output fpba_pkg::rsp_t                      out_data,
    input  logic [fpba_pkg::FIT_POLICY_W-1:0]   fit_policy,
    input  logic [fpba_pkg::BIU_W-1:0]          blocks_in_use,
    output logic                                mem_we,
    output logic [IDX_W-1:0]                    mem_waddr,
    output logic [SIZE_BITS-1:0]                mem_wdata,
    output logic [IDX_W-1:0]                    mem_raddr,
    input  logic [SIZE_BITS-1:0]                mem_rdata
);
    import fpba_pkg::*;

    localparam int LW = (CNT_W > BIU_W) ? CNT_W : BIU_W;
    localparam logic [LW-1:0] NB_L = LW'(NUM_BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_WRITE  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    req_t                 item_reg, item_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_size_reg, best_size_next;
    rsp_t                 res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    rsp_t                 out_data_reg, out_data_next;

    logic [SIZE_BITS-1:0] amt_sz;
    logic [LW-1:0]        biu_ext;
    logic [CNT_W-1:0]     search_cnt;
    logic                 is_best;
    logic                 is_worst;
    logic                 fits;
    logic                 take;
    logic                 last;
    logic                 load_ok;

    assign amt_sz     = SIZE_BITS'(item_reg.amount);
    assign biu_ext    = LW'(blocks_in_use);
    assign search_cnt = (biu_ext > NB_L) ? CNT_W'(NB_L) : CNT_W'(biu_ext);
    assign is_best    = (fit_policy == POLICY_BEST);
    assign is_worst   = (fit_policy == POLICY_WORST);
    assign load_ok    = (LW'(item_reg.load_index) < NB_L);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_raddr      = idx_reg + IDX_W'(1);
        mem_we         = 1'b0;
        mem_waddr      = best_idx_reg;
        mem_wdata      = best_size_reg - amt_sz;
        fits           = 1'b0;
        take           = 1'b0;
        last           = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (in_valid)
                begin
                    item_next  = in_data;
                    found_next = 1'b0;
                    idx_next   = '0;
                    if (in_data.req_type == REQ_LOAD || search_cnt == '0)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // read data belongs to entry idx_reg
                fits = (mem_rdata >= amt_sz);
                take = fits && (!found_reg
                                || (is_best  && mem_rdata < best_size_reg)
                                || (is_worst && mem_rdata > best_size_reg));
                last = ((CNT_W'(idx_reg) + CNT_W'(1)) == search_cnt);
                if (take)
                begin
                    found_next     = 1'b1;
                    best_idx_next  = idx_reg;
                    best_size_next = mem_rdata;
                end
                // first fit stops at the first entry that fits
                if (last || (fits && !is_best && !is_worst))
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_WRITE:
            begin
                if (item_reg.req_type == REQ_LOAD)
                begin
                    mem_we                = load_ok;
                    mem_waddr             = IDX_W'(item_reg.load_index);
                    mem_wdata             = amt_sz;
                    res_next.granted      = 1'b0;
                    res_next.chosen_block = CHOSEN_W'(item_reg.load_index);
                    res_next.left_over    = load_ok ? LEFT_W'(amt_sz) : '0;
                end
                else if (found_reg)
                begin
                    mem_we                = 1'b1;
                    res_next.granted      = 1'b1;
                    res_next.chosen_block = CHOSEN_W'(best_idx_reg);
                    res_next.left_over    = LEFT_W'(best_size_reg - amt_sz);
                end
                else
                begin
                    res_next = '0;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        idx_reg       <= idx_next;
        found_reg     <= found_next;
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
        res_reg       <= res_next;
        out_data_reg  <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ bench/fit_policy_block_allocator_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_checker
// Watches the request, response and register ports of the allocator. It keeps
// its own free-size table and policy settings, predicts the response to every
// accepted request and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_checker #(
    parameter int NUM_BLOCKS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    input  logic                             req_ready,
    input  fpba_pkg::req_t                   req_data,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  fpba_pkg::rsp_t                   rsp_data,
    input  logic                             cfg_we,
    input  logic [fpba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatches,
    output int                               outstanding,
    output int                               grant_count
);
    import fpba_pkg::*;

    logic [AMOUNT_W-1:0]     free_table [NUM_BLOCKS];
    logic [FIT_POLICY_W-1:0] policy;
    logic [BIU_W-1:0]        search_len;
    rsp_t                    awaited_responses [$];
    int                      errors = 0;
    int                      granted_total = 0;

    // updates the table as the block should and returns the response
    function automatic rsp_t predict_response(input req_t r);
        rsp_t        res;
        int unsigned limit;
        bit          found;
        int unsigned pick;
        res   = '0;
        found = 1'b0;
        pick  = 0;
        limit = (search_len > NUM_BLOCKS) ? NUM_BLOCKS : search_len;
        if (r.req_type == REQ_LOAD)
        begin
            free_table[r.load_index] = r.amount;
            res.chosen_block         = r.load_index;
            res.left_over            = r.amount;
        end
        else
        begin
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                if (i < limit && free_table[i] >= r.amount)
                begin
                    // first fit (and the unused code) keeps the first hit
                    if (!found)
                    begin
                        found = 1'b1;
                        pick  = i;
                    end
                    else if (policy == POLICY_BEST && free_table[i] < free_table[pick])
                        pick = i;
                    else if (policy == POLICY_WORST && free_table[i] > free_table[pick])
                        pick = i;
                end
            end
            if (found)
            begin
                free_table[pick] = free_table[pick] - r.amount;
                res.granted      = 1'b1;
                res.chosen_block = CHOSEN_W'(pick);
                res.left_over    = free_table[pick];
            end
        end
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            foreach (free_table[i])
                free_table[i] = '0;
            policy     = FIT_POLICY_RESET;
            search_len = BIU_RESET;
            awaited_responses.delete();
        end
        else
        begin
            // responses first: one can never belong to a request taken at this edge
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_responses.size() == 0)
                begin
                    errors++;
                    $error("response with no request outstanding");
                end
                else
                begin
                    want = awaited_responses.pop_front();
                    check_field("granted", 32'(want.granted), 32'(rsp_data.granted));
                    check_field("chosen_block", 32'(want.chosen_block),
                                32'(rsp_data.chosen_block));
                    check_field("left_over", 32'(want.left_over), 32'(rsp_data.left_over));
                    if (want.granted)
                        granted_total++;
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIT_POLICY)
                    policy = cfg_wdata[FIT_POLICY_W-1:0];
                else if (cfg_index == CFG_BLOCKS_IN_USE)
                    search_len = cfg_wdata[BIU_W-1:0];
            end
            if (req_valid && req_ready)
                awaited_responses.push_back(predict_response(req_data));
        end
        mismatches  <= errors;
        outstanding <= awaited_responses.size();
        grant_count <= granted_total;
    end

endmodule

@@ bench/fit_policy_block_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// Drives load and allocate requests into the allocator under every fit
// policy and a range of search lengths, with random gaps and back-pressure.
// A checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
    import fpba_pkg::*;

    localparam int NUM_BLOCKS  = 16;
    localparam int SIZE_BITS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int NUM_PHASES  = 13;
    localparam int PLANNED     = 10;
    localparam int PHASE_ITEMS = 50;

    localparam logic [FIT_POLICY_W-1:0] POLICY_UNUSED = 2'd3;

    localparam logic [FIT_POLICY_W-1:0] POLICY_PLAN [PLANNED] = '{
        POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_UNUSED, POLICY_BEST,
        POLICY_WORST, POLICY_FIRST, POLICY_BEST, POLICY_WORST, POLICY_FIRST
    };
    localparam logic [BIU_W-1:0] COUNT_PLAN [PLANNED] = '{
        5'd16, 5'd16, 5'd16, 5'd16, 5'd1, 5'd0, 5'd17, 5'd31, 5'd5, 5'd9
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    fpba_chan_if #(.payload_t(req_t)) req_ch ();
    fpba_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    int unsigned cycles = 0;
    int          fail_count;
    int          pending;
    int          grants;
    int          loads_sent = 0;
    int          allocs_sent = 0;
    int          settings_used = 1;
    bit          sender_steady = 1'b0;

    fit_policy_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fit_policy_block_allocator_checker #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_data    (req_ch.data),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_data    (rsp_ch.data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (fail_count),
        .outstanding (pending),
        .grant_count (grants)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        @(posedge clk);
        while (cycles < CYCLE_LIMIT)
            @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    // response side back-pressure, with a quiet window of no stalls
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= (cycles >= 4000 && cycles < 7000) || ($urandom_range(99) >= 6);
        end
    end

    // mix of zeros, full-scale, repeated sizes for ties, small and wide values
    function automatic logic [AMOUNT_W-1:0] random_amount();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8)
            return '0;
        if (pick < 14)
            return '1;
        if (pick < 40)
            return AMOUNT_W'(64 * $urandom_range(1, 8));
        if (pick < 75)
            return AMOUNT_W'($urandom_range(1, 3000));
        return AMOUNT_W'($urandom);
    endfunction

    task automatic send_item(input logic kind, input logic [LOAD_IDX_W-1:0] idx,
                             input logic [AMOUNT_W-1:0] amt);
        req_t item;
        int   gap;
        item.req_type   = kind;
        item.load_index = idx;
        item.amount     = amt;
        gap = 0;
        if (!sender_steady && $urandom_range(99) < 6)
            gap = $urandom_range(1, 5);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (kind == REQ_LOAD)
            loads_sent++;
        else
            allocs_sent++;
    endtask

    // wait until every request has its response, plus a little slack
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic set_config(input logic [FIT_POLICY_W-1:0] pol, input logic [BIU_W-1:0] count);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIT_POLICY;
        // spare data bits above the policy field are noise
        cfg_wdata <= {3'($urandom_range(7)), pol};
        @(posedge clk);
        cfg_index <= CFG_BLOCKS_IN_USE;
        cfg_wdata <= count;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= CFG_FIT_POLICY;
        cfg_wdata    <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, zero request, no fit, extremes, ties
        send_item(REQ_ALLOCATE, 4'h0, 16'h0000);
        send_item(REQ_ALLOCATE, 4'hF, 16'h0001);
        send_item(REQ_LOAD, 4'hF, 16'hFFFF);
        send_item(REQ_LOAD, 4'h0, 16'h0000);
        send_item(REQ_LOAD, 4'h5, 16'd100);
        send_item(REQ_LOAD, 4'h3, 16'd300);
        send_item(REQ_LOAD, 4'h9, 16'd200);
        send_item(REQ_LOAD, 4'hA, 16'hAAAA);
        send_item(REQ_LOAD, 4'h6, 16'h5555);
        send_item(REQ_ALLOCATE, 4'h0, 16'hFFFF);
        send_item(REQ_ALLOCATE, 4'h0, 16'hFFFF);
        send_item(REQ_ALLOCATE, 4'h0, 16'd150);
        drain();
        set_config(POLICY_BEST, 5'd16);
        send_item(REQ_LOAD, 4'hC, 16'd100);
        send_item(REQ_ALLOCATE, 4'h0, 16'd60);
        send_item(REQ_ALLOCATE, 4'h0, 16'h0000);
        drain();
        set_config(POLICY_WORST, 5'd16);
        send_item(REQ_ALLOCATE, 4'h0, 16'h0001);
        send_item(REQ_LOAD, 4'h2, 16'hFFFF);
        send_item(REQ_ALLOCATE, 4'h0, 16'd1000);
        drain();
        // nothing searched, yet loads still answer
        set_config(POLICY_UNUSED, 5'd0);
        send_item(REQ_ALLOCATE, 4'h0, 16'h0000);
        send_item(REQ_LOAD, 4'h7, 16'd7);
        drain();
        // oversized search length saturates to the table size
        set_config(POLICY_UNUSED, 5'd31);
        send_item(REQ_ALLOCATE, 4'h0, 16'd100);
        send_item(REQ_ALLOCATE, 4'h0, 16'd1);
        drain();

        // random phases: fill the table, then mixed loads and allocations
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p < PLANNED)
                set_config(POLICY_PLAN[p], COUNT_PLAN[p]);
            else
                set_config(FIT_POLICY_W'($urandom_range(3)), BIU_W'($urandom_range(31)));
            sender_steady = (p == 3);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k < NUM_BLOCKS)
                    send_item(REQ_LOAD, LOAD_IDX_W'(k), random_amount());
                else if ($urandom_range(99) < 35)
                    send_item(REQ_LOAD, LOAD_IDX_W'($urandom), random_amount());
                else
                    send_item(REQ_ALLOCATE, LOAD_IDX_W'($urandom), random_amount());
            end
            drain();
        end

        repeat (20) @(posedge clk);
        $display("ran %0d loads and %0d allocate requests over %0d register settings,",
                 loads_sent, allocs_sent, settings_used);
        $display("%0d allocations granted, %0d mismatches", grants, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/fpba_pkg.sv
rtl/fpba_chan_if.sv
rtl/fpba_mem.sv
rtl/fpba_ctrl.sv
rtl/fit_policy_block_allocator.sv
bench/fit_policy_block_allocator_checker.sv
bench/fit_policy_block_allocator_tb.sv
